@@ rtl/core/dpa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_pkg
// shared types, widths and constants of the int8 dot product accumulator
// ----------------------------------------------------------------------------
package dpa_pkg;

    localparam int SUM_W  = 26;   // dot_sum width
    localparam int SIM_W  = 28;   // similarity_q16 width
    localparam int ELEM_W = 8;
    localparam int PROD_W = 16;
    localparam int PSUM_W = 18;   // sum of four products
    localparam int ACC_W  = 28;   // running sum plus one group, with headroom

    localparam int Q_FRAC     = 16;
    localparam int SIM_DIV    = 16129;
    localparam int ROUND_HALF = (SIM_DIV - 1) / 2;

    // exact reciprocals: floor(n / SIM_DIV) == (n * RCP) >> SHIFT
    localparam int MAG_W       = SUM_W;
    localparam int RCP1_SHIFT  = 40;
    localparam int RCP1_W      = 27;
    localparam int QA_W        = 12;
    localparam int RA_W        = 14;
    localparam int N2_W        = RA_W + Q_FRAC;
    localparam int RCP2_SHIFT  = 44;
    localparam int RCP2_W      = 31;
    localparam int PROD1_W     = MAG_W + RCP1_W;
    localparam int PROD2_W     = N2_W + RCP2_W;

    localparam logic [RCP1_W-1:0] RCP1 =
        RCP1_W'(((64'd1 << RCP1_SHIFT) + 64'(SIM_DIV) - 64'd1) / 64'(SIM_DIV));
    localparam logic [RCP2_W-1:0] RCP2 =
        RCP2_W'(((64'd1 << RCP2_SHIFT) + 64'(SIM_DIV) - 64'd1) / 64'(SIM_DIV));

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef logic signed [SUM_W-1:0] dpa_sum_t;

    typedef struct packed {
        logic empty;
        logic afull;
    } dpa_q_stat_t;

    function automatic longint dpa_sum_lo(input longint max_dims);
        longint lo;
        lo = -64'sd16256 * max_dims;
        if (lo < -(64'sd1 <<< (SUM_W - 1))) begin
            lo = -(64'sd1 <<< (SUM_W - 1));
        end
        return lo;
    endfunction

    function automatic longint dpa_sum_hi(input longint max_dims);
        longint hi;
        hi = 64'sd16384 * max_dims;
        if (hi > (64'sd1 <<< (SUM_W - 1)) - 64'sd1) begin
            hi = (64'sd1 <<< (SUM_W - 1)) - 64'sd1;
        end
        return hi;
    endfunction

endpackage

@@ rtl/core/dpa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_front
// accepts lane beats, forms the four products and keeps the running sum
// ----------------------------------------------------------------------------
module dpa_front #(
    parameter int MAX_DIMS = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  a_lane0,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  a_lane1,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  a_lane2,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  a_lane3,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  b_lane0,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  b_lane1,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  b_lane2,
    input  logic signed [dpa_pkg::ELEM_W-1:0]  b_lane3,
    input  logic                               last,
    input  dpa_pkg::dpa_q_stat_t               q_stat,
    output logic                               push,
    output dpa_pkg::dpa_sum_t                  push_data
);

    localparam logic signed [dpa_pkg::ACC_W-1:0] ACC_LO =
        dpa_pkg::ACC_W'(dpa_pkg::dpa_sum_lo(longint'(MAX_DIMS)));
    localparam logic signed [dpa_pkg::ACC_W-1:0] ACC_HI =
        dpa_pkg::ACC_W'(dpa_pkg::dpa_sum_hi(longint'(MAX_DIMS)));

    logic signed [dpa_pkg::PROD_W-1:0] p0, p1, p2, p3;
    logic signed [dpa_pkg::PSUM_W-1:0] psum;
    logic                              accept;

    logic                              f1_valid_reg, f1_valid_next;
    logic                              f1_last_reg;
    logic signed [dpa_pkg::PSUM_W-1:0] f1_psum_reg;

    dpa_pkg::dpa_sum_t                 running_reg, running_next;
    logic signed [dpa_pkg::ACC_W-1:0]  acc_wide;
    dpa_pkg::dpa_sum_t                 acc_clamped;

    // one slot is held back for the beat sitting in the product stage
    assign in_ready = !q_stat.afull;
    assign accept   = in_valid && in_ready;

    assign p0   = a_lane0 * b_lane0;
    assign p1   = a_lane1 * b_lane1;
    assign p2   = a_lane2 * b_lane2;
    assign p3   = a_lane3 * b_lane3;
    assign psum = (dpa_pkg::PSUM_W'(p0) + dpa_pkg::PSUM_W'(p1))
                + (dpa_pkg::PSUM_W'(p2) + dpa_pkg::PSUM_W'(p3));

    assign f1_valid_next = accept;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            f1_valid_reg <= 1'b0;
            running_reg  <= '0;
        end else begin
            f1_valid_reg <= f1_valid_next;
            running_reg  <= running_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            f1_psum_reg <= psum;
            f1_last_reg <= last;
        end
    end

    // saturating accumulate
    always_comb begin
        acc_wide = dpa_pkg::ACC_W'(running_reg) + dpa_pkg::ACC_W'(f1_psum_reg);
        if (acc_wide < ACC_LO) begin
            acc_clamped = dpa_pkg::SUM_W'(ACC_LO);
        end else if (acc_wide > ACC_HI) begin
            acc_clamped = dpa_pkg::SUM_W'(ACC_HI);
        end else begin
            acc_clamped = dpa_pkg::SUM_W'(acc_wide);
        end
    end

    always_comb begin
        running_next = running_reg;
        if (f1_valid_reg) begin
            running_next = f1_last_reg ? '0 : acc_clamped;
        end
    end

    assign push      = f1_valid_reg && f1_last_reg;
    assign push_data = acc_clamped;

endmodule

@@ rtl/core/dpa_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_queue
// short fifo of finished sums between the front and the back
// ----------------------------------------------------------------------------
module dpa_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dpa_pkg::dpa_sum_t    push_data,
    input  logic                 pop,
    output dpa_pkg::dpa_sum_t    pop_data,
    output dpa_pkg::dpa_q_stat_t q_stat
);

    dpa_pkg::dpa_sum_t                mem_reg [dpa_pkg::QUEUE_DEPTH];
    logic [dpa_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [dpa_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [dpa_pkg::QCNT_W-1:0]       count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + dpa_pkg::QPTR_W'(push);
        rd_ptr_next = rd_ptr_reg + dpa_pkg::QPTR_W'(pop);
        count_next  = count_reg + dpa_pkg::QCNT_W'(push) - dpa_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == '0);
    assign q_stat.afull = (count_reg >= dpa_pkg::QCNT_W'(dpa_pkg::QUEUE_DEPTH - 1));

endmodule

@@ rtl/core/dpa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_back
// scales each finished sum to q16 by 1/16129 and holds the result beat
// ----------------------------------------------------------------------------
module dpa_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dpa_pkg::dpa_q_stat_t              q_stat,
    input  dpa_pkg::dpa_sum_t                 pop_data,
    output logic                              pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [dpa_pkg::SUM_W-1:0]  dot_sum,
    output logic signed [dpa_pkg::SIM_W-1:0]  similarity_q16
);

    localparam logic signed [dpa_pkg::SIM_W:0] SIM_MAX =
        (dpa_pkg::SIM_W + 1)'((64'sd1 <<< (dpa_pkg::SIM_W - 1)) - 64'sd1);
    localparam logic signed [dpa_pkg::SIM_W:0] SIM_MIN =
        (dpa_pkg::SIM_W + 1)'(-(64'sd1 <<< (dpa_pkg::SIM_W - 1)));

    logic adv;

    logic                            v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic                            ov_reg, ov_next;

    // stage 1: magnitude and coarse quotient
    logic [dpa_pkg::MAG_W-1:0]       mag;
    logic [dpa_pkg::PROD1_W-1:0]     prod1;
    dpa_pkg::dpa_sum_t               s1_sum_reg;
    logic [dpa_pkg::MAG_W-1:0]       s1_mag_reg;
    logic [dpa_pkg::QA_W-1:0]        s1_qa_reg;

    // stage 2: remainder of the coarse quotient
    logic [dpa_pkg::MAG_W-1:0]       qd;
    dpa_pkg::dpa_sum_t               s2_sum_reg;
    logic [dpa_pkg::QA_W-1:0]        s2_qa_reg;
    logic [dpa_pkg::RA_W-1:0]        s2_ra_reg;

    // stage 3: fine quotient of the remainder scaled by 2^16
    logic [dpa_pkg::N2_W-1:0]        n2;
    logic [dpa_pkg::PROD2_W-1:0]     prod2;
    dpa_pkg::dpa_sum_t               s3_sum_reg;
    logic [dpa_pkg::QA_W-1:0]        s3_qa_reg;
    logic [dpa_pkg::Q_FRAC-1:0]      s3_q2_reg;

    // output stage: sign and saturate
    logic [dpa_pkg::SIM_W-1:0]       qmag;
    logic signed [dpa_pkg::SIM_W:0]  qsig;
    logic signed [dpa_pkg::SIM_W-1:0] sim_sat;

    assign adv = !ov_reg || out_ready;
    assign pop = adv && !q_stat.empty;

    assign v1_next = adv ? pop    : v1_reg;
    assign v2_next = adv ? v1_reg : v2_reg;
    assign v3_next = adv ? v2_reg : v3_reg;
    assign ov_next = adv ? v3_reg : ov_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ov_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            ov_reg <= ov_next;
        end
    end

    always_comb begin
        mag   = pop_data[dpa_pkg::SUM_W-1] ? dpa_pkg::MAG_W'(-pop_data)
                                           : dpa_pkg::MAG_W'(pop_data);
        prod1 = dpa_pkg::PROD1_W'(mag) * dpa_pkg::PROD1_W'(dpa_pkg::RCP1);
        qd    = dpa_pkg::MAG_W'(s1_qa_reg) * dpa_pkg::MAG_W'(dpa_pkg::SIM_DIV);
        n2    = {s2_ra_reg, dpa_pkg::Q_FRAC'(0)} + dpa_pkg::N2_W'(dpa_pkg::ROUND_HALF);
        prod2 = dpa_pkg::PROD2_W'(n2) * dpa_pkg::PROD2_W'(dpa_pkg::RCP2);
        qmag  = {s3_qa_reg, s3_q2_reg};
        if (s3_sum_reg[dpa_pkg::SUM_W-1]) begin
            qsig = -$signed({1'b0, qmag});
        end else begin
            qsig = $signed({1'b0, qmag});
        end
        if (qsig > SIM_MAX) begin
            sim_sat = dpa_pkg::SIM_W'(SIM_MAX);
        end else if (qsig < SIM_MIN) begin
            sim_sat = dpa_pkg::SIM_W'(SIM_MIN);
        end else begin
            sim_sat = dpa_pkg::SIM_W'(qsig);
        end
    end

    always_ff @(posedge clk) begin
        if (adv) begin
            s1_sum_reg     <= pop_data;
            s1_mag_reg     <= mag;
            s1_qa_reg      <= prod1[dpa_pkg::RCP1_SHIFT +: dpa_pkg::QA_W];
            s2_sum_reg     <= s1_sum_reg;
            s2_qa_reg      <= s1_qa_reg;
            s2_ra_reg      <= dpa_pkg::RA_W'(s1_mag_reg - qd);
            s3_sum_reg     <= s2_sum_reg;
            s3_qa_reg      <= s2_qa_reg;
            s3_q2_reg      <= prod2[dpa_pkg::RCP2_SHIFT +: dpa_pkg::Q_FRAC];
            dot_sum        <= s3_sum_reg;
            similarity_q16 <= sim_sat;
        end
    end

    assign out_valid = ov_reg;

endmodule

@@ rtl/core/int8_dot_product_accumulator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_dot_product_accumulator_top
// streaming signed int8 dot product with q16 cosine-style scaling
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_ready  | a_lane0..3, b_lane0..3 (s8), last
//  output   | out_valid / out_ready| dot_sum (s26), similarity_q16 (s28)
//
//  one input beat per cycle while in_ready is high; each vector sum passes
//  the product register, the queue, the scaling stages and output register
//  the running sum is a single loop: add the four products, saturate, store
//  rst_n clears the running sum, the queue and all valid flags at once
//  a stalled output freezes the scaling pipeline; the queue then fills and
//  in_ready drops once three sums wait, so beats keep flowing until then
//
module int8_dot_product_accumulator_top #(
    parameter int MAX_DIMS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [7:0]                 a_lane0,
    input  logic signed [7:0]                 a_lane1,
    input  logic signed [7:0]                 a_lane2,
    input  logic signed [7:0]                 a_lane3,
    input  logic signed [7:0]                 b_lane0,
    input  logic signed [7:0]                 b_lane1,
    input  logic signed [7:0]                 b_lane2,
    input  logic signed [7:0]                 b_lane3,
    input  logic                              last,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [dpa_pkg::SUM_W-1:0]  dot_sum,
    output logic signed [dpa_pkg::SIM_W-1:0]  similarity_q16
);

    // front to queue: finished sums of whole vectors
    logic                 push;
    dpa_pkg::dpa_sum_t    push_data;

    // queue to back
    logic                 pop;
    dpa_pkg::dpa_sum_t    pop_data;
    dpa_pkg::dpa_q_stat_t q_stat;

    // product tree and saturating accumulator
    dpa_front #(
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_lane0   (a_lane0),
        .a_lane1   (a_lane1),
        .a_lane2   (a_lane2),
        .a_lane3   (a_lane3),
        .b_lane0   (b_lane0),
        .b_lane1   (b_lane1),
        .b_lane2   (b_lane2),
        .b_lane3   (b_lane3),
        .last      (last),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    // decouples accumulation from the scaling pipeline
    dpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    // reciprocal-multiply divide by 16129 with round to nearest
    dpa_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .pop_data       (pop_data),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .dot_sum        (dot_sum),
        .similarity_q16 (similarity_q16)
    );

endmodule

@@ rtl/core/dpa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpa_checker
// port-level checks of the dot product accumulator, bound to the top level
// ----------------------------------------------------------------------------
module dpa_checker #(
    parameter int MAX_DIMS = 1024
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              last,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [dpa_pkg::SUM_W-1:0]  dot_sum,
    input logic signed [dpa_pkg::SIM_W-1:0]  similarity_q16
);

    localparam logic signed [dpa_pkg::SUM_W-1:0] SUM_LO =
        dpa_pkg::SUM_W'(dpa_pkg::dpa_sum_lo(longint'(MAX_DIMS)));
    localparam logic signed [dpa_pkg::SUM_W-1:0] SUM_HI =
        dpa_pkg::SUM_W'(dpa_pkg::dpa_sum_hi(longint'(MAX_DIMS)));

    // vectors closed at the input and not yet delivered
    logic [4:0] pend_reg, pend_next;

    assign pend_next = pend_reg + 5'(in_valid && in_ready && last)
                     - 5'(out_valid && out_ready);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dot_sum)
                                    && $stable(similarity_q16))
        else $error("result beat changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 5'd0)
        else $error("result beat without a closed vector");

    a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dot_sum[dpa_pkg::SUM_W-1] == similarity_q16[dpa_pkg::SIM_W-1])
        else $error("similarity sign differs from dot sum sign");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dot_sum >= SUM_LO && dot_sum <= SUM_HI)
        else $error("dot sum outside saturation range");

endmodule

bind int8_dot_product_accumulator_top dpa_checker #(
    .MAX_DIMS (MAX_DIMS)
) u_dpa_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .last           (last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dot_sum        (dot_sum),
    .similarity_q16 (similarity_q16)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the int8 dot product accumulator: streams vector
// groups through the input channel, predicts each dot sum and its q16
// similarity, and checks every result beat in order under random idling
// ----------------------------------------------------------------------------
module tb;

    localparam int     DIMS        = 1024;
    localparam int     QUIET_LIMIT = 4000;  // cycles with no beat on either side
    localparam int     TAIL_CYCLES = 24;    // idle tail after the last result has come back
    localparam int     LANES       = 4;

    // limits of the running sum, from the lane extremes times the vector length
    localparam longint SUM_MIN_W = -(64'sd1 <<< (dpa_pkg::SUM_W - 1));
    localparam longint SUM_MAX_W = (64'sd1 <<< (dpa_pkg::SUM_W - 1)) - 64'sd1;
    localparam longint SUM_LO_R  = -64'sd16256 * DIMS;
    localparam longint SUM_HI_R  = 64'sd16384 * DIMS;
    localparam longint SUM_LO    = (SUM_LO_R < SUM_MIN_W) ? SUM_MIN_W : SUM_LO_R;
    localparam longint SUM_HI    = (SUM_HI_R > SUM_MAX_W) ? SUM_MAX_W : SUM_HI_R;
    localparam longint SIM_MIN_W = -(64'sd1 <<< (dpa_pkg::SIM_W - 1));
    localparam longint SIM_MAX_W = (64'sd1 <<< (dpa_pkg::SIM_W - 1)) - 64'sd1;

    typedef logic signed [dpa_pkg::SIM_W-1:0] sim_t;

    typedef struct packed {
        logic [LANES-1:0][7:0] a;
        logic [LANES-1:0][7:0] b;
        logic                  last;
    } group_t;

    typedef struct packed {
        dpa_pkg::dpa_sum_t sum;
        sim_t              sim;
    } dot_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic signed [7:0] a_lane0 = '0;
    logic signed [7:0] a_lane1 = '0;
    logic signed [7:0] a_lane2 = '0;
    logic signed [7:0] a_lane3 = '0;
    logic signed [7:0] b_lane0 = '0;
    logic signed [7:0] b_lane1 = '0;
    logic signed [7:0] b_lane2 = '0;
    logic signed [7:0] b_lane3 = '0;
    logic              last = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    dpa_pkg::dpa_sum_t dot_sum;
    sim_t              similarity_q16;

    // knobs shared by the test tasks and the receiver
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                hold_len = 0;
    int                hold_seq = 0;
    int                hold_seen = 0;
    int                hold_left = 0;

    int                errors = 0;
    int                quiet_cycles = 0;
    longint            running_dot = 0;
    dot_result_t       expected_dots[$];

    int8_dot_product_accumulator_top #(
        .MAX_DIMS(DIMS)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .a_lane0(a_lane0),
        .a_lane1(a_lane1),
        .a_lane2(a_lane2),
        .a_lane3(a_lane3),
        .b_lane0(b_lane0),
        .b_lane1(b_lane1),
        .b_lane2(b_lane2),
        .b_lane3(b_lane3),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .dot_sum(dot_sum),
        .similarity_q16(similarity_q16)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // sum * 2^16 / 16129, rounded to nearest on the magnitude, then saturated
    function automatic sim_t q16_similarity(input longint s);
        longint mag;
        longint q;
        mag = (s < 0 ? -s : s) <<< dpa_pkg::Q_FRAC;
        q = (2 * mag + dpa_pkg::SIM_DIV) / (2 * dpa_pkg::SIM_DIV);
        if (s < 0)
            q = -q;
        if (q < SIM_MIN_W)
            q = SIM_MIN_W;
        if (q > SIM_MAX_W)
            q = SIM_MAX_W;
        return sim_t'(q);
    endfunction

    // fold one accepted group into the running dot product; a last beat
    // closes the vector, queues its result and clears the sum
    function automatic void accumulate_dot(input group_t g);
        longint      total;
        dot_result_t r;
        total = running_dot;
        for (int k = 0; k < LANES; k++)
            total += longint'($signed(g.a[k])) * longint'($signed(g.b[k]));
        // saturate at every step, not only at the end of the vector
        if (total < SUM_LO)
            total = SUM_LO;
        if (total > SUM_HI)
            total = SUM_HI;
        if (g.last)
        begin
            r.sum = dpa_pkg::dpa_sum_t'(total);
            r.sim = q16_similarity(total);
            expected_dots.push_back(r);
            running_dot = 0;
        end
        else
            running_dot = total;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic group_t make_group(input int a0, input int a1, input int a2,
                                          input int a3, input int b0, input int b1,
                                          input int b2, input int b3, input bit lst);
        group_t g;
        g.a[0] = 8'(a0);
        g.a[1] = 8'(a1);
        g.a[2] = 8'(a2);
        g.a[3] = 8'(a3);
        g.b[0] = 8'(b0);
        g.b[1] = 8'(b1);
        g.b[2] = 8'(b2);
        g.b[3] = 8'(b3);
        g.last = lst;
        return g;
    endfunction

    // lane value leaning on the extremes and on zero
    function automatic logic [7:0] pick_lane();
        case ($urandom_range(7))
            0:       return 8'h80;
            1:       return 8'h7f;
            2:       return 8'h00;
            3:       return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic group_t random_group(input bit lst);
        group_t g;
        for (int k = 0; k < LANES; k++)
        begin
            g.a[k] = pick_lane();
            g.b[k] = pick_lane();
        end
        g.last = lst;
        return g;
    endfunction

    // offer one group and hold it until the block takes it; valid stays
    // high afterwards so back-to-back beats need no gap
    task automatic send_group(input group_t g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        a_lane0  <= g.a[0];
        a_lane1  <= g.a[1];
        a_lane2  <= g.a[2];
        a_lane3  <= g.a[3];
        b_lane0  <= g.b[0];
        b_lane1  <= g.b[1];
        b_lane2  <= g.b[2];
        b_lane3  <= g.b[3];
        last     <= g.last;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        accumulate_dot(g);
    endtask

    // sender goes quiet until every queued result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_dots.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // lane extremes, single-lane vectors, sign handling and rounding
    task automatic test_directed();
        send_group(make_group(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_group(make_group(-128, -128, -128, -128, -128, -128, -128, -128, 1'b1));
        send_group(make_group(-128, -128, -128, -128, 127, 127, 127, 127, 1'b1));
        send_group(make_group(127, 127, 127, 127, 127, 127, 127, 127, 1'b1));
        send_group(make_group(127, 127, 127, 127, -128, -128, -128, -128, 1'b1));
        // each lane alone, four beats into one vector
        send_group(make_group(-128, 0, 0, 0, -128, 0, 0, 0, 1'b0));
        send_group(make_group(0, -128, 0, 0, 0, -128, 0, 0, 1'b0));
        send_group(make_group(0, 0, -128, 0, 0, 0, -128, 0, 1'b0));
        send_group(make_group(0, 0, 0, -128, 0, 0, 0, -128, 1'b1));
        // smallest magnitudes: rounding on both signs
        send_group(make_group(1, 0, 0, 0, 1, 0, 0, 0, 1'b1));
        send_group(make_group(-1, 0, 0, 0, 1, 0, 0, 0, 1'b1));
        send_group(make_group(0, 0, 0, 3, 0, 0, 0, -1, 1'b1));
        // mixed signs across three beats
        send_group(make_group(5, -7, 100, -100, 3, 3, -3, -3, 1'b0));
        send_group(make_group(-1, -1, -1, -1, -1, -1, -1, -1, 1'b0));
        send_group(make_group(85, -86, 85, -86, -86, 85, -86, 85, 1'b1));
        // two beats of mixed extremes
        send_group(make_group(127, -128, 64, -1, 127, 127, 127, 127, 1'b0));
        send_group(make_group(-127, 127, -64, 1, 127, 128, 127, 127, 1'b1));
        wait_drained();
    endtask

    // overlong vectors drive the running sum into both clamps; later
    // beats then count from the clamped value
    task automatic test_saturation();
        for (int n = 0; n < 260; n++)
            send_group(make_group(-128, -128, -128, -128, -128, -128, -128, -128,
                                  1'b0));
        send_group(make_group(127, 127, 127, 127, -128, -128, -128, -128, 1'b1));
        for (int n = 0; n < 258; n++)
            send_group(make_group(127, 127, 127, 127, -128, -128, -128, -128, 1'b0));
        send_group(make_group(127, 127, 127, 127, 127, 127, 127, 127, 1'b1));
        wait_drained();
    endtask

    // random vectors, mostly short, now and then a long one
    task automatic test_random_vectors(input int beats, input int idle_pct,
                                       input int stall_pct);
        int sent;
        int len;
        sent = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < beats)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
            for (int n = 0; n < len; n++)
                send_group(random_group(n == len - 1));
            sent += len;
        end
        wait_drained();
    endtask

    // output held off for a long stretch while one-beat vectors keep coming,
    // so the result queue fills and the input stalls
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 200;
        hold_seq = hold_seq + 1;
        for (int n = 0; n < 24; n++)
            send_group(random_group(1'b1));
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls, plus a long hold on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // result checking: each accepted beat against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        dot_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_dots.size() == 0)
            begin
                $error("result beat with none expected: dot_sum %0d similarity_q16 %0d",
                       dot_sum, similarity_q16);
                errors++;
            end
            else
            begin
                want = expected_dots.pop_front();
                if (dot_sum !== want.sum)
                begin
                    $error("dot_sum: expected %0d, got %0d", want.sum, dot_sum);
                    errors++;
                end
                if (similarity_q16 !== want.sim)
                begin
                    $error("similarity_q16: expected %0d, got %0d", want.sim,
                           similarity_q16);
                    errors++;
                end
            end
        end
    end

    // watchdog: a run with no beat on either side for too long is hung
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_saturation();
        test_random_vectors(40, 0, 0);
        test_random_vectors(40, 81, 0);
        test_output_hold();
        test_random_vectors(40, 0, 81);
        test_random_vectors(40, 33, 33);

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/dpa_pkg.sv
rtl/core/dpa_front.sv
rtl/core/dpa_queue.sv
rtl/core/dpa_back.sv
rtl/core/int8_dot_product_accumulator_top.sv
rtl/core/dpa_checker.sv
bench/tb.sv
